// ===== hdl/scalar_kalman_filter_defines.svh =====
// assertion macros for the scalar kalman filter
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// antecedent holds in the same cycle as the consequent
`define SKF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SKF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/skf_pkg.sv =====
// shared constants and types for the scalar kalman filter
package skf_pkg;

   localparam int GAIN_FRAC_BITS = 16;
   localparam int VALUE_W        = 15;
   localparam int VAR_W          = 16;
   localparam int DEN_W          = VAR_W + 1;
   localparam int REM_W          = DEN_W + 1;
   localparam int ACC_W          = VAR_W + GAIN_FRAC_BITS;
   localparam int CNT_W          = $clog2(GAIN_FRAC_BITS + 1);
   localparam int CSR_IDX_W      = 1;
   localparam int TDATA_W        = ((VALUE_W + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 1'd1;

   localparam logic [VAR_W-1:0] PROCESS_NOISE_RST = 16'd26;
   localparam logic [VAR_W-1:0] MEASURE_NOISE_RST = 16'd192;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_UPDATE
   } state_type;

endpackage

// ===== hdl/scalar_kalman_filter.sv =====
// scalar kalman filter top level: bit-serial gain division with merged shift-add products
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/req_tready req_tdata[14:0] measurement
//   rsp      out        rsp_tvalid/rsp_tready rsp_tdata[14:0] estimate
//   csr      in         csr_we                csr_index, csr_wdata
//
// an item passes through an accept state, a setup state, 17 restoring-division
// steps (one gain bit each, GAIN_FRAC_BITS + 1) and a writeback that can stall; the
// result beat is registered at writeback, and the next item is accepted only back in idle.
// both products ride along the division, one gain bit per step, msb first.
// reset is synchronous: estimate and variance clear to zero, noises to 26 and 192.
// writeback waits while a previous result sits unaccepted in the output register.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [skf_pkg::TDATA_W-1:0]         req_tdata,   // [14:0] measurement, [15] ignored
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [skf_pkg::TDATA_W-1:0]         rsp_tdata,   // [14:0] estimate, [15] zero
   input  logic                                csr_we,
   input  logic [skf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [skf_pkg::VAR_W-1:0]           csr_wdata
);

   skf_pkg::state_type state_ff, state_in;

   logic [skf_pkg::VAR_W-1:0]   process_noise_ff;
   logic [skf_pkg::VAR_W-1:0]   measure_noise_ff;
   logic [skf_pkg::VALUE_W-1:0] est_value_ff, est_value_in;
   logic [skf_pkg::VAR_W-1:0]   est_variance_ff, est_variance_in;
   logic [skf_pkg::VALUE_W-1:0] meas_ff, meas_in;
   logic [skf_pkg::VAR_W-1:0]   p_raw_ff, p_raw_in;
   logic [skf_pkg::DEN_W-1:0]   denom_ff, denom_in;
   logic                        neg_ff, neg_in;
   logic [skf_pkg::VALUE_W-1:0] diff_ff, diff_in;
   logic [skf_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [skf_pkg::ACC_W-1:0]   acc_d_ff, acc_d_in;
   logic [skf_pkg::ACC_W-1:0]   acc_p_ff, acc_p_in;
   logic [skf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        out_valid_ff, out_valid_in;
   logic [skf_pkg::VALUE_W-1:0] out_data_ff, out_data_in;

   logic [skf_pkg::DEN_W-1:0]   p_sum;
   logic                        rem_ge;
   logic                        qbit;
   logic [skf_pkg::REM_W-1:0]   rem_sub;
   logic [skf_pkg::VALUE_W-1:0] delta;
   logic [skf_pkg::VAR_W-1:0]   p_drop;
   logic                        out_free;

   assign req_tready = (state_ff == skf_pkg::ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(skf_pkg::TDATA_W - skf_pkg::VALUE_W){1'b0}}, out_data_ff};
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      est_value_in    = est_value_ff;
      est_variance_in = est_variance_ff;
      meas_in         = meas_ff;
      p_raw_in        = p_raw_ff;
      denom_in        = denom_ff;
      neg_in          = neg_ff;
      diff_in         = diff_ff;
      rem_in          = rem_ff;
      acc_d_in        = acc_d_ff;
      acc_p_in        = acc_p_ff;
      cnt_in          = cnt_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      out_data_in     = out_data_ff;

      // predicted variance, saturating
      p_sum = {1'b0, est_variance_ff} + {1'b0, process_noise_ff};

      // one restoring-division step; zero denominator gives zero gain
      rem_ge  = rem_ff >= {1'b0, denom_ff};
      qbit    = rem_ge && (denom_ff != '0);
      rem_sub = rem_ge ? (rem_ff - {1'b0, denom_ff}) : rem_ff;

      delta  = acc_d_ff[skf_pkg::GAIN_FRAC_BITS +: skf_pkg::VALUE_W];
      p_drop = acc_p_ff[skf_pkg::ACC_W-1:skf_pkg::GAIN_FRAC_BITS]
               + {{(skf_pkg::VAR_W-1){1'b0}}, |acc_p_ff[skf_pkg::GAIN_FRAC_BITS-1:0]};

      unique case (state_ff)
         skf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               meas_in  = req_tdata[skf_pkg::VALUE_W-1:0];
               p_raw_in = p_sum[skf_pkg::VAR_W] ? '1 : p_sum[skf_pkg::VAR_W-1:0];
               state_in = skf_pkg::ST_PREP;
            end
         end
         skf_pkg::ST_PREP: begin
            denom_in = {1'b0, p_raw_ff} + {1'b0, measure_noise_ff};
            neg_in   = meas_ff < est_value_ff;
            diff_in  = (meas_ff < est_value_ff) ? (est_value_ff - meas_ff)
                                                : (meas_ff - est_value_ff);
            rem_in   = {2'b00, p_raw_ff};
            acc_d_in = '0;
            acc_p_in = '0;
            cnt_in   = skf_pkg::CNT_W'(skf_pkg::GAIN_FRAC_BITS);
            state_in = skf_pkg::ST_DIV;
         end
         skf_pkg::ST_DIV: begin
            rem_in   = {rem_sub[skf_pkg::REM_W-2:0], 1'b0};
            acc_d_in = {acc_d_ff[skf_pkg::ACC_W-2:0], 1'b0}
                       + (qbit ? {{(skf_pkg::ACC_W-skf_pkg::VALUE_W){1'b0}}, diff_ff} : '0);
            acc_p_in = {acc_p_ff[skf_pkg::ACC_W-2:0], 1'b0}
                       + (qbit ? {{(skf_pkg::ACC_W-skf_pkg::VAR_W){1'b0}}, p_raw_ff} : '0);
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = skf_pkg::ST_UPDATE;
            end
         end
         skf_pkg::ST_UPDATE: begin
            if (out_free) begin
               est_value_in    = neg_ff ? (est_value_ff - delta) : (est_value_ff + delta);
               est_variance_in = p_raw_ff - p_drop;
               out_data_in     = neg_ff ? (est_value_ff - delta) : (est_value_ff + delta);
               out_valid_in    = 1'b1;
               state_in        = skf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= skf_pkg::ST_IDLE;
         out_valid_ff     <= 1'b0;
         est_value_ff     <= '0;
         est_variance_ff  <= '0;
         process_noise_ff <= skf_pkg::PROCESS_NOISE_RST;
         measure_noise_ff <= skf_pkg::MEASURE_NOISE_RST;
      end else begin
         state_ff        <= state_in;
         out_valid_ff    <= out_valid_in;
         est_value_ff    <= est_value_in;
         est_variance_ff <= est_variance_in;
         if (csr_we) begin
            unique case (csr_index)
               skf_pkg::CSR_PROCESS_NOISE: process_noise_ff <= csr_wdata;
               skf_pkg::CSR_MEASURE_NOISE: measure_noise_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      p_raw_ff    <= p_raw_in;
      denom_ff    <= denom_in;
      neg_ff      <= neg_in;
      diff_ff     <= diff_in;
      rem_ff      <= rem_in;
      acc_d_ff    <= acc_d_in;
      acc_p_ff    <= acc_p_in;
      cnt_ff      <= cnt_in;
      out_data_ff <= out_data_in;
   end

   `SKF_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == skf_pkg::ST_PREP, "accepted beat did not start setup")
   `SKF_ASSERT_SAME(a_rem_bound, clock, reset, (state_ff == skf_pkg::ST_DIV) && (denom_ff != '0), (rem_ff < {denom_ff, 1'b0}), "division remainder out of range")
   `SKF_ASSERT_NEXT(a_var_shrinks, clock, reset, (state_ff == skf_pkg::ST_UPDATE) && out_free, est_variance_ff <= $past(p_raw_ff), "updated variance exceeds prediction")
   `SKF_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == skf_pkg::ST_UPDATE) && out_free, rsp_tvalid && (rsp_tdata[skf_pkg::VALUE_W-1:0] == est_value_ff), "result beat does not match stored estimate")

endmodule
